// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, all on the rising clock edge and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

   localparam int PIX_W       = 8;
   localparam int QUO_W       = 8;
   localparam int X_W         = 11;
   localparam int NUM_W       = 19;
   localparam int DEN_W       = 11;
   localparam int STEP_BITS   = 2;
   localparam int DIV_STAGES  = QUO_W / STEP_BITS;
   localparam int PIPE_STAGES = DIV_STAGES + 2;

   typedef logic [PIX_W-1:0] pix_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rgbhsv_div.sv =====
`default_nettype none

module rgbhsv_div import rgbhsv_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [DIV_STAGES-1:0] en,
   input  wire logic [NUM_W-1:0]      dividend,
   input  wire logic [DEN_W-1:0]      divisor,
   output logic      [QUO_W-1:0]      quotient
);

   // restoring division, STEP_BITS quotient bits per stage, quotient known to fit QUO_W
   logic [NUM_W-1:0] rem_prev [DIV_STAGES];
   logic [DEN_W-1:0] den_prev [DIV_STAGES];
   logic [QUO_W-1:0] quo_prev [DIV_STAGES];
   logic [NUM_W-1:0] rem_in   [DIV_STAGES];
   logic [QUO_W-1:0] quo_in   [DIV_STAGES];
   logic [NUM_W-1:0] rem_ff   [DIV_STAGES];
   logic [DEN_W-1:0] den_ff   [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff   [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int SH = QUO_W - 1 - j * STEP_BITS;

      if (j == 0) begin : g_first
         assign rem_prev[j] = dividend;
         assign den_prev[j] = divisor;
         assign quo_prev[j] = '0;
      end else begin : g_next
         assign rem_prev[j] = rem_ff[j-1];
         assign den_prev[j] = den_ff[j-1];
         assign quo_prev[j] = quo_ff[j-1];
      end

      always_comb begin : step
         logic [NUM_W-1:0] rem;
         logic [NUM_W-1:0] trial;
         logic [QUO_W-1:0] quo;
         rem = rem_prev[j];
         quo = quo_prev[j];
         for (int k = 0; k < STEP_BITS; k++) begin
            trial = NUM_W'(den_prev[j]) << (SH - k);
            if (rem >= trial) begin
               rem          = rem - trial;
               quo[SH - k]  = 1'b1;
            end
         end
         rem_in[j] = rem;
         quo_in[j] = quo;
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_prev[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_hsv_pixel_core.sv =====
`default_nettype none
// RGB to HSV pixel converter, 8 bits per channel.
// Input channel req_: one RGB word (req_red, req_green, req_blue) is taken at a
// rising edge where req_valid is high and req_stall is low.
// Result channel rsp_: hue code, saturation and brightness (the channel
// maximum), taken where rsp_valid is high and rsp_stall is low.
// Hue is floor(hue_degrees * 255 / 360), 0 for a grey pixel; saturation is
// floor((max - min) * 255 / max), 0 for a black pixel.
// Six register stages: a min/max and sector stage, a scaling stage, then
// two 4-stage restoring dividers (2 quotient bits per stage) running side
// by side. Throughput is one word per clock while rsp_stall is low.
// Each stage carries a valid bit; a stage loads when it is empty or its
// successor moves, so bubbles close up under backpressure.
// With rsp_stall high the output word holds; req_stall rises only once all
// six stages are full. Synchronous reset empties the pipeline; no state is
// kept between words.

module rgb_to_hsv_pixel_core import rgbhsv_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [PIX_W-1:0] req_red,
   input  wire logic [PIX_W-1:0] req_green,
   input  wire logic [PIX_W-1:0] req_blue,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [QUO_W-1:0]     rsp_hue_code,
   output logic [QUO_W-1:0]     rsp_saturation,
   output logic [PIX_W-1:0]     rsp_brightness
);

   `include "assert_macros.svh"

   logic [PIPE_STAGES-1:0] v_ff;
   logic [PIPE_STAGES-1:0] v_in;
   logic [PIPE_STAGES-1:0] ready;
   pix_type                mx_ff [PIPE_STAGES];

   pix_type                mx_in;
   pix_type                mn;
   pix_type                d_in;
   logic [X_W-1:0]         x_in;
   pix_type                d_ff;
   logic [X_W-1:0]         x_ff;

   logic [NUM_W-1:0]       num_h_in, num_h_ff, num_s_in, num_s_ff;
   logic [DEN_W-1:0]       den_h_in, den_h_ff, den_s_in, den_s_ff;

   // flow control
   always_comb begin
      ready[PIPE_STAGES-1] = !v_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         ready[i] = !v_ff[i] || ready[i+1];
      end
      for (int i = 0; i < PIPE_STAGES; i++) begin
         if (i == 0) begin
            v_in[i] = ready[i] ? req_valid : v_ff[i];
         end else begin
            v_in[i] = ready[i] ? v_ff[i-1] : v_ff[i];
         end
      end
   end

   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 0: max, min, spread, sector position with each sixth of the hue circle spanning d
   always_comb begin
      mx_in = (req_red > req_green) ? req_red : req_green;
      mx_in = (mx_in > req_blue) ? mx_in : req_blue;
      mn    = (req_red < req_green) ? req_red : req_green;
      mn    = (mn < req_blue) ? mn : req_blue;
      d_in  = mx_in - mn;
      priority if (mx_in == req_red) begin
         if (req_green >= req_blue) begin
            x_in = X_W'(req_green - req_blue);
         end else begin
            x_in = (X_W'(d_in) << 2) + (X_W'(d_in) << 1) - X_W'(req_blue - req_green);
         end
      end else if (mx_in == req_green) begin
         x_in = (X_W'(d_in) << 1) + X_W'(req_blue) - X_W'(req_red);
      end else begin
         x_in = (X_W'(d_in) << 2) + X_W'(req_red) - X_W'(req_green);
      end
   end

   // stage 1: dividends and divisors; zero divisors become 1 (dividend is 0 then)
   always_comb begin
      num_h_in = (NUM_W'(x_ff) << PIX_W) - NUM_W'(x_ff);
      den_h_in = (d_ff == '0) ? DEN_W'(1) : (DEN_W'(d_ff) << 2) + (DEN_W'(d_ff) << 1);
      num_s_in = (NUM_W'(d_ff) << PIX_W) - NUM_W'(d_ff);
      den_s_in = (mx_ff[0] == '0) ? DEN_W'(1) : DEN_W'(mx_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         mx_ff[0] <= mx_in;
         d_ff     <= d_in;
         x_ff     <= x_in;
      end
      if (ready[1]) begin
         num_h_ff <= num_h_in;
         den_h_ff <= den_h_in;
         num_s_ff <= num_s_in;
         den_s_ff <= den_s_in;
      end
   end

   for (genvar i = 1; i < PIPE_STAGES; i++) begin : g_mx
      always_ff @(posedge clock) begin
         if (ready[i]) begin
            mx_ff[i] <= mx_ff[i-1];
         end
      end
   end

   rgbhsv_div u_hue_div (
      .clock    (clock),
      .en       (ready[PIPE_STAGES-1:2]),
      .dividend (num_h_ff),
      .divisor  (den_h_ff),
      .quotient (rsp_hue_code)
   );

   rgbhsv_div u_sat_div (
      .clock    (clock),
      .en       (ready[PIPE_STAGES-1:2]),
      .dividend (num_s_ff),
      .divisor  (den_s_ff),
      .quotient (rsp_saturation)
   );

   assign rsp_valid      = v_ff[PIPE_STAGES-1];
   assign rsp_brightness = mx_ff[PIPE_STAGES-1];

   `ASSERT_NEVER(a_hue_range, clock, reset, rsp_valid && rsp_hue_code == {QUO_W{1'b1}})
   `ASSERT_HOLDS(a_black_sat, clock, reset, rsp_valid && rsp_brightness == '0 |-> rsp_saturation == '0)
   `ASSERT_HOLDS(a_stall_full, clock, reset, req_stall |-> v_ff == {PIPE_STAGES{1'b1}})

endmodule

`default_nettype wire
